@@ src/csp_pkg.sv @@
// ----------------------------------------------------------------------------
// csp_pkg
// Types and constants for the clipped 13-bit sample packer.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int CODE_BITS      = 13;
  localparam int SAMPLE_BITS    = 16;
  localparam int BUDGET_BITS    = 13;
  localparam int CFG_DATA_BITS  = 13;

  localparam logic signed [SAMPLE_BITS-1:0] SIGNED_LIMIT   = 16'sd2500;
  localparam logic signed [SAMPLE_BITS-1:0] UNSIGNED_LIMIT = 16'sd5000;

  localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = 13'd4096;

  // register indexes
  localparam logic REG_UNSIGNED_MODE = 1'b0;
  localparam logic REG_BUFFER_BYTES  = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_NEG_ABORT = 2'd1,
    KIND_FULL_ABORT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       run_last;
    logic       frame_done;
  } result_t;

endpackage

@@ src/clipped_13bit_sample_packer.sv @@
// ----------------------------------------------------------------------------
// clipped_13bit_sample_packer
// Clips samples to 13-bit codes, packs them LSB first and streams out bytes.
// ----------------------------------------------------------------------------
// The first byte of a sample leaves from the result buffer after the sample
// has passed the input register. The single output port drains the 3-entry
// result buffer at one byte per cycle while m_tready is high.
// A new request may enter while the last buffered byte is being taken.
// Reset (rst, synchronous): empties the pipeline, clears frame state and
// restores unsigned_mode = 0, buffer_bytes = 4096.
module clipped_13bit_sample_packer
  import csp_pkg::*;
#(
  parameter int MAX_BUFFER_BYTES = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [15:0]              s_tdata,   // [15:0] sample_tenths
  input  logic                     s_tlast,   // frame_last
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata,   // [7:0] out_byte
  output logic [2:0]               m_tuser,   // [1:0] kind, [2] frame_done
  output logic                     m_tlast    // run_last
);

  logic                   unsigned_mode;
  logic [BUDGET_BITS-1:0] buffer_bytes;

  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_last;

  logic [7:0]             acc;
  logic [2:0]             bit_count;
  logic [BUDGET_BITS-1:0] bytes_written;
  logic                   frame_aborted;

  result_t    res [3];
  logic [1:0] cnt;

  logic load;
  logic pop;

  result_t                res_next [3];
  logic [1:0]             cnt_load;
  logic [7:0]             acc_next;
  logic [2:0]             bit_count_next;
  logic [BUDGET_BITS-1:0] bytes_written_next;
  logic                   frame_aborted_next;

  assign pop      = m_tvalid && m_tready;
  assign load     = in_valid && ((cnt == 2'd0) || ((cnt == 2'd1) && pop));
  assign s_tready = !in_valid || load;

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = res[0].out_byte;
  assign m_tuser  = {res[0].frame_done, res[0].kind};
  assign m_tlast  = res[0].run_last;

  // one sample: clip, pack, split into up to three results
  always_comb begin
    logic [BUDGET_BITS-1:0]        budget;
    logic signed [SAMPLE_BITS-1:0] clip;
    logic [CODE_BITS-1:0]          code;
    logic [19:0]                   packed_bits;
    logic                          two_bytes;
    logic [7:0]                    leftover;
    logic [BUDGET_BITS:0]          bw1;
    logic [BUDGET_BITS-1:0]        bw_end;
    result_t                       empty;

    empty = '{out_byte: 8'd0, kind: KIND_DATA, run_last: 1'b0, frame_done: 1'b0};
    res_next[0] = empty;
    res_next[1] = empty;
    res_next[2] = empty;
    cnt_load = 2'd0;
    acc_next = acc;
    bit_count_next = bit_count;
    bytes_written_next = bytes_written;
    frame_aborted_next = frame_aborted;

    if (32'(buffer_bytes) > MAX_BUFFER_BYTES) begin
      budget = BUDGET_BITS'(MAX_BUFFER_BYTES);
    end else begin
      budget = buffer_bytes;
    end

    if (unsigned_mode) begin
      clip = (in_sample > UNSIGNED_LIMIT) ? UNSIGNED_LIMIT : in_sample;
    end else if (in_sample > SIGNED_LIMIT) begin
      clip = UNSIGNED_LIMIT;
    end else if (in_sample < -SIGNED_LIMIT) begin
      clip = '0;
    end else begin
      clip = in_sample + SIGNED_LIMIT;
    end
    code = clip[CODE_BITS-1:0];

    packed_bits = {12'd0, acc} | ({7'd0, code} << bit_count);
    two_bytes   = (bit_count >= 3'd3);
    leftover    = two_bytes ? {4'd0, packed_bits[19:16]} : packed_bits[15:8];
    bw1         = {1'b0, bytes_written} + 1'b1;
    bw_end      = two_bytes ? BUDGET_BITS'(bw1 + 1'b1) : bw1[BUDGET_BITS-1:0];

    if (frame_aborted) begin
      if (in_last) begin
        frame_aborted_next = 1'b0;
      end
    end else if (unsigned_mode && in_sample[SAMPLE_BITS-1]) begin
      res_next[0] = '{out_byte: 8'd0, kind: KIND_NEG_ABORT, run_last: 1'b1,
                      frame_done: 1'b1};
      cnt_load = 2'd1;
      frame_aborted_next = !in_last;
    end else if (bytes_written >= budget) begin
      res_next[0] = '{out_byte: 8'd0, kind: KIND_FULL_ABORT, run_last: 1'b1,
                      frame_done: 1'b1};
      cnt_load = 2'd1;
      frame_aborted_next = !in_last;
    end else begin
      res_next[0].out_byte = packed_bits[7:0];
      if (two_bytes && (bw1 >= {1'b0, budget})) begin
        res_next[1] = '{out_byte: 8'd0, kind: KIND_FULL_ABORT, run_last: 1'b1,
                        frame_done: 1'b1};
        cnt_load = 2'd2;
        frame_aborted_next = !in_last;
      end else begin
        if (two_bytes) begin
          res_next[1].out_byte = packed_bits[15:8];
        end
        cnt_load = two_bytes ? 2'd2 : 2'd1;
        acc_next = leftover;
        bit_count_next = two_bytes ? 3'(bit_count - 3'd3) : 3'(bit_count + 3'd5);
        bytes_written_next = bw_end;
        if (in_last) begin
          if (bw_end < budget) begin
            res_next[cnt_load].out_byte = leftover;
            cnt_load = cnt_load + 2'd1;
          end
          res_next[cnt_load - 2'd1].frame_done = 1'b1;
        end
        res_next[cnt_load - 2'd1].run_last = 1'b1;
      end
    end

    if (in_last) begin
      acc_next = '0;
      bit_count_next = '0;
      bytes_written_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unsigned_mode <= 1'b0;
      buffer_bytes  <= BUDGET_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_UNSIGNED_MODE: unsigned_mode <= cfg_wdata[0];
        REG_BUFFER_BYTES:  buffer_bytes  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_sample <= s_tdata;
      in_last   <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      bit_count     <= '0;
      bytes_written <= '0;
      frame_aborted <= 1'b0;
    end else if (load) begin
      acc           <= acc_next;
      bit_count     <= bit_count_next;
      bytes_written <= bytes_written_next;
      frame_aborted <= frame_aborted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= cnt_load;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res[0] <= res_next[0];
      res[1] <= res_next[1];
      res[2] <= res_next[2];
    end else if (pop) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3 || !(res[2].run_last === 1'b0 && res[2].kind != KIND_DATA))
    else $error("result buffer entry inconsistent");

  a_abort_ends_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res[0].kind != KIND_DATA) |-> (m_tlast && m_tuser[2]))
    else $error("abort result must close run and frame");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !load) |-> !s_tready)
    else $error("input register overwritten while busy");

  a_frame_done_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> m_tlast)
    else $error("frame end without run end");
`endif

endmodule
